/* design/mm3_pkg.sv */
// Shared types, constants and helpers of the 3x3 matrix product engine.
`default_nettype none
package mm3_pkg;

	localparam int ELEMENTS = 9;
	localparam int IDX_W = 4;
	localparam int ELEM_W = 32;
	localparam int OPND_W = 33;
	localparam int PROD_W = 2 * OPND_W;
	localparam int ACC_W = 70;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int DRAIN_CYCLES = 4;

	typedef enum logic [2:0] {
		MODE_AB       = 3'd0,
		MODE_COLCROSS = 3'd1,
		MODE_AHAT     = 3'd2,
		MODE_ABC      = 3'd3,
		MODE_COLNORM  = 3'd4,
		MODE_ROWNORM  = 3'd5,
		MODE_ATBC     = 3'd6,
		MODE_UNUSED   = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		SEL_A = 2'd0,
		SEL_B = 2'd1,
		SEL_C = 2'd2,
		SEL_V = 2'd3
	} opsel_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		DEST_RES,
		DEST_E,
		DEST_S
	} dest_t;

	// one multiply step issued by the controller
	typedef struct packed {
		logic             valid;
		logic             first;
		logic             last;
		logic             pass;
		mode_t            mode;
		logic [IDX_W-1:0] k;
		logic [1:0]       term;
	} cmd_t;

	// element load
	typedef struct packed {
		logic              we;
		opsel_t            sel;
		logic [IDX_W-1:0]  idx;
		logic [ELEM_W-1:0] value;
	} load_t;

	function automatic logic [1:0] row_of(input logic [IDX_W-1:0] k);
		logic [1:0] r;
		case (k)
			4'd0, 4'd3, 4'd6: r = 2'd0;
			4'd1, 4'd4, 4'd7: r = 2'd1;
			default:          r = 2'd2;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] col_of(input logic [IDX_W-1:0] k);
		logic [1:0] c;
		case (k)
			4'd0, 4'd1, 4'd2: c = 2'd0;
			4'd3, 4'd4, 4'd5: c = 2'd1;
			default:          c = 2'd2;
		endcase
		return c;
	endfunction

	// column-major position of row r, column c
	function automatic logic [IDX_W-1:0] elem(input logic [1:0] r, input logic [1:0] c);
		return {2'b00, r} + {1'b0, c, 1'b0} + {2'b00, c};
	endfunction

endpackage
`default_nettype wire

/* design/mm3_cmd_if.sv */
// Input channel: element loads and run requests.
`default_nettype none
interface mm3_cmd_if;
	logic       valid;
	logic       ready;
	logic       run;
	logic [2:0] mode;
	logic [1:0] operand_select;
	logic [3:0] element_index;
	logic signed [31:0] element_value;

	modport source(output valid, run, mode, operand_select, element_index, element_value,
		input ready);
	modport sink(input valid, run, mode, operand_select, element_index, element_value,
		output ready);
endinterface
`default_nettype wire

/* design/mm3_res_if.sv */
// Output channel: result elements.
`default_nettype none
interface mm3_res_if;
	logic       valid;
	logic       ready;
	logic [3:0] result_index;
	logic signed [31:0] result_value;
	logic       overflow;
	logic       last;

	modport source(output valid, result_index, result_value, overflow, last, input ready);
	modport sink(input valid, result_index, result_value, overflow, last, output ready);
endinterface
`default_nettype wire

/* design/matrix3x3_product_engine_top.sv */
// Top level of the 3x3 matrix product engine.
// A load is written straight into the operand store. A run computes each dot product on
// the single shared multiplier (9 dot products, or 18 for A*B*C and transpose(A)*B*C, 12
// for the norm modes), drains after each pass, then emits nine result words, one per cycle
// while res.ready is high. Throughput: one load word per cycle while idle; one run at a time.
// Reset: arst_n clears the sequencer and pipeline valids; the operand stores keep no reset.
`default_nettype none
module matrix3x3_product_engine_top #(
	parameter int VALUE_WIDTH   = mm3_pkg::VALUE_WIDTH_DEF,
	parameter int FRACTION_BITS = mm3_pkg::FRACTION_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	mm3_cmd_if.sink  cmd,
	mm3_res_if.source res
);
	mm3_pkg::cmd_t  step;
	mm3_pkg::load_t ld;
	logic [mm3_pkg::IDX_W-1:0] emit_idx;
	logic emit_last;
	logic in_ready;
	logic out_valid;
	logic signed [mm3_pkg::ELEM_W-1:0] res_value;
	logic res_ovf;

	// Load word: written straight into the operand store.
	always_comb begin
		ld.we    = cmd.valid && in_ready && !cmd.run;
		ld.sel   = mm3_pkg::opsel_t'(cmd.operand_select);
		ld.idx   = cmd.element_index;
		ld.value = cmd.element_value;
	end

	// Sequencer: one multiply step per cycle, then the result words.
	mm3_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_run    (cmd.run),
		.in_mode   (mm3_pkg::mode_t'(cmd.mode)),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (res.ready),
		.emit_idx  (emit_idx),
		.emit_last (emit_last),
		.cmd       (step)
	);

	// Stores, shared multiply-accumulate and result buffer.
	mm3_dp #(
		.VALUE_WIDTH   (VALUE_WIDTH),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ld        (ld),
		.cmd       (step),
		.emit_idx  (emit_idx),
		.res_value (res_value),
		.res_ovf   (res_ovf)
	);

	assign cmd.ready        = in_ready;
	assign res.valid        = out_valid;
	assign res.result_index = emit_idx;
	assign res.result_value = res_value;
	assign res.overflow     = res_ovf;
	assign res.last         = emit_last;

endmodule
`default_nettype wire

/* design/mm3_ctrl.sv */
// Controller: sequences multiply steps, drains and result emission.
`default_nettype none
module mm3_ctrl (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	input  wire logic                    in_run,
	input  wire mm3_pkg::mode_t          in_mode,
	output logic                         in_ready,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [mm3_pkg::IDX_W-1:0]    emit_idx,
	output logic                         emit_last,
	output mm3_pkg::cmd_t                cmd
);
	mm3_pkg::state_t state_q, state_d;
	mm3_pkg::mode_t  mode_q;
	logic            pass_q;
	logic [mm3_pkg::IDX_W-1:0] op_q;
	logic [1:0]      term_q;
	logic [2:0]      drain_q;
	logic [mm3_pkg::IDX_W-1:0] emit_q;
	logic            two_pass;
	logic            short_pass;
	logic [mm3_pkg::IDX_W-1:0] op_last;
	logic            run_go;

	assign two_pass = (mode_q == mm3_pkg::MODE_ABC) || (mode_q == mm3_pkg::MODE_ATBC) ||
		(mode_q == mm3_pkg::MODE_COLNORM) || (mode_q == mm3_pkg::MODE_ROWNORM);
	// first-pass dot products of the norm modes: three ops
	assign short_pass = !pass_q &&
		((mode_q == mm3_pkg::MODE_COLNORM) || (mode_q == mm3_pkg::MODE_ROWNORM));
	assign op_last = short_pass ? mm3_pkg::IDX_W'(2) : mm3_pkg::IDX_W'(mm3_pkg::ELEMENTS - 1);
	assign run_go = in_valid && in_ready && in_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mm3_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			mm3_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && in_run) state_d = mm3_pkg::ST_CALC;
			end
			mm3_pkg::ST_CALC: begin
				if (term_q == 2'd3 && op_q == op_last) state_d = mm3_pkg::ST_DRAIN;
			end
			mm3_pkg::ST_DRAIN: begin
				if (drain_q == 3'(mm3_pkg::DRAIN_CYCLES - 1)) begin
					state_d = (two_pass && !pass_q) ? mm3_pkg::ST_CALC : mm3_pkg::ST_EMIT;
				end
			end
			mm3_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready && emit_last) state_d = mm3_pkg::ST_IDLE;
			end
			default: state_d = mm3_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= mm3_pkg::MODE_AB;
			pass_q  <= 1'b0;
			op_q    <= '0;
			term_q  <= '0;
			drain_q <= '0;
			emit_q  <= '0;
		end else begin
			if (run_go) begin
				mode_q <= in_mode;
				pass_q <= 1'b0;
				op_q   <= '0;
				term_q <= '0;
				emit_q <= '0;
			end
			if (state_q == mm3_pkg::ST_CALC) begin
				term_q <= term_q + 2'd1;
				if (term_q == 2'd3) begin
					op_q <= (op_q == op_last) ? '0 : op_q + 1'b1;
				end
				drain_q <= '0;
			end
			if (state_q == mm3_pkg::ST_DRAIN) begin
				drain_q <= drain_q + 3'd1;
				if (drain_q == 3'(mm3_pkg::DRAIN_CYCLES - 1)) pass_q <= 1'b1;
			end
			if (state_q == mm3_pkg::ST_EMIT && out_ready) begin
				emit_q <= emit_q + 1'b1;
			end
		end
	end

	assign emit_idx  = emit_q;
	assign emit_last = (emit_q == mm3_pkg::IDX_W'(mm3_pkg::ELEMENTS - 1));

	always_comb begin
		cmd       = '0;
		cmd.valid = (state_q == mm3_pkg::ST_CALC);
		cmd.first = (term_q == 2'd0);
		cmd.last  = (term_q == 2'd3);
		cmd.pass  = pass_q;
		cmd.mode  = mode_q;
		cmd.k     = op_q;
		cmd.term  = term_q;
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input and output open together");
	a_back_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && emit_last |=> in_ready) else $error("no return to idle");
	a_op_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid |-> op_q <= mm3_pkg::IDX_W'(mm3_pkg::ELEMENTS - 1)) else $error("op index");
	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> emit_q <= mm3_pkg::IDX_W'(mm3_pkg::ELEMENTS - 1)) else $error("emit index");

endmodule
`default_nettype wire

/* design/mm3_dp.sv */
// Datapath: operand stores, shared multiply-accumulate, round and saturate.
`default_nettype none
module mm3_dp #(
	parameter int VALUE_WIDTH   = mm3_pkg::VALUE_WIDTH_DEF,
	parameter int FRACTION_BITS = mm3_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire mm3_pkg::load_t             ld,
	input  wire mm3_pkg::cmd_t              cmd,
	input  wire logic [mm3_pkg::IDX_W-1:0]  emit_idx,
	output logic signed [mm3_pkg::ELEM_W-1:0] res_value,
	output logic                            res_ovf
);
	localparam int AW = mm3_pkg::ACC_W;
	localparam int HELD = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
	localparam logic signed [AW-1:0] HALF = AW'((64'sd1 <<< FRACTION_BITS) >>> 1);
	localparam logic signed [AW-1:0] SAT_MAX = AW'((64'sd1 <<< (HELD - 1)) - 64'sd1);
	localparam logic signed [AW-1:0] SAT_MIN = -SAT_MAX - AW'(1);
	localparam logic signed [mm3_pkg::OPND_W-1:0] ONE =
		mm3_pkg::OPND_W'(64'sd1 <<< FRACTION_BITS);

	typedef struct packed {
		logic                      valid;
		logic                      first;
		logic                      last;
		mm3_pkg::dest_t            dest;
		logic [mm3_pkg::IDX_W-1:0] k;
	} ctl_t;

	logic signed [mm3_pkg::ELEM_W-1:0] a_q [mm3_pkg::ELEMENTS];
	logic signed [mm3_pkg::ELEM_W-1:0] b_q [mm3_pkg::ELEMENTS];
	logic signed [mm3_pkg::ELEM_W-1:0] c_q [mm3_pkg::ELEMENTS];
	logic signed [mm3_pkg::ELEM_W-1:0] v_q [3];
	logic signed [mm3_pkg::ELEM_W-1:0] e_q [mm3_pkg::ELEMENTS];
	logic                              ef_q [mm3_pkg::ELEMENTS];
	logic signed [mm3_pkg::ELEM_W-1:0] s_q [3];
	logic                              sf_q [3];
	logic signed [mm3_pkg::ELEM_W-1:0] r_q [mm3_pkg::ELEMENTS];
	logic                              rf_q [mm3_pkg::ELEMENTS];

	logic signed [mm3_pkg::OPND_W-1:0] x_d, y_d, x_s1, y_s1;
	logic xf_d, f_s1, f_s2, f_acc_q, f_s3;
	ctl_t ctl_d, ctl_s1, ctl_s2, ctl_s3;
	logic signed [mm3_pkg::PROD_W-1:0] prod_s2;
	logic signed [AW-1:0] acc_q, acc_n, sum_s3, rnd;
	logic f_n, sat_hi, sat_lo;
	logic signed [mm3_pkg::ELEM_W-1:0] out_v;
	logic [1:0] r, c, g;
	logic [1:0] j;
	logic rows;

	function automatic logic signed [mm3_pkg::OPND_W-1:0] sx(
		input logic signed [mm3_pkg::ELEM_W-1:0] v);
		return mm3_pkg::OPND_W'(v);
	endfunction

	// loads
	always_ff @(posedge clk) begin
		if (ld.we) begin
			case (ld.sel)
				mm3_pkg::SEL_A: if (ld.idx < mm3_pkg::IDX_W'(9)) a_q[ld.idx] <= ld.value;
				mm3_pkg::SEL_B: if (ld.idx < mm3_pkg::IDX_W'(9)) b_q[ld.idx] <= ld.value;
				mm3_pkg::SEL_C: if (ld.idx < mm3_pkg::IDX_W'(9)) c_q[ld.idx] <= ld.value;
				default:        if (ld.idx < mm3_pkg::IDX_W'(3)) v_q[ld.idx[1:0]] <= ld.value;
			endcase
		end
	end

	// operand selection for one step
	always_comb begin
		r = mm3_pkg::row_of(cmd.k);
		c = mm3_pkg::col_of(cmd.k);
		j = cmd.term;
		rows = (cmd.mode == mm3_pkg::MODE_ROWNORM);
		g = rows ? r : c;
		x_d = '0;
		y_d = '0;
		xf_d = 1'b0;
		case (cmd.mode) inside
			mm3_pkg::MODE_AB, mm3_pkg::MODE_ABC, mm3_pkg::MODE_ATBC: begin
				if (j != 2'd3) begin
					if (!cmd.pass) begin
						x_d = (cmd.mode == mm3_pkg::MODE_ATBC) ? sx(a_q[mm3_pkg::elem(j, r)])
							: sx(a_q[mm3_pkg::elem(r, j)]);
						y_d = sx(b_q[mm3_pkg::elem(j, c)]);
					end else begin
						x_d  = sx(e_q[mm3_pkg::elem(r, j)]);
						xf_d = ef_q[mm3_pkg::elem(r, j)];
						y_d  = sx(c_q[mm3_pkg::elem(j, c)]);
					end
				end
			end
			mm3_pkg::MODE_COLCROSS: begin
				if (j == 2'd0) begin
					case (r)
						2'd0:    begin x_d = sx(v_q[2]);  y_d = sx(a_q[mm3_pkg::elem(2'd1, c)]); end
						2'd1:    begin x_d = -sx(v_q[2]); y_d = sx(a_q[mm3_pkg::elem(2'd0, c)]); end
						default: begin x_d = sx(v_q[1]);  y_d = sx(a_q[mm3_pkg::elem(2'd0, c)]); end
					endcase
				end else if (j == 2'd1) begin
					case (r)
						2'd0:    begin x_d = -sx(v_q[1]); y_d = sx(a_q[mm3_pkg::elem(2'd2, c)]); end
						2'd1:    begin x_d = sx(v_q[0]);  y_d = sx(a_q[mm3_pkg::elem(2'd2, c)]); end
						default: begin x_d = -sx(v_q[0]); y_d = sx(a_q[mm3_pkg::elem(2'd1, c)]); end
					endcase
				end
			end
			mm3_pkg::MODE_AHAT: begin
				if (j != 2'd3) begin
					x_d = sx(a_q[mm3_pkg::elem(r, j)]);
					// hat matrix element at row j, column c
					case (mm3_pkg::elem(j, c))
						4'd1:    y_d = -sx(v_q[2]);
						4'd2:    y_d = sx(v_q[1]);
						4'd3:    y_d = sx(v_q[2]);
						4'd5:    y_d = -sx(v_q[0]);
						4'd6:    y_d = -sx(v_q[1]);
						4'd7:    y_d = sx(v_q[0]);
						default: y_d = '0;
					endcase
				end
			end
			mm3_pkg::MODE_COLNORM, mm3_pkg::MODE_ROWNORM: begin
				if (!cmd.pass) begin
					if (j != 2'd3) begin
						x_d = rows ? sx(a_q[mm3_pkg::elem(cmd.k[1:0], j)])
							: sx(a_q[mm3_pkg::elem(j, cmd.k[1:0])]);
						y_d = sx(v_q[j]);
					end
				end else if (j == 2'd0) begin
					x_d  = sx(s_q[g]);
					xf_d = sf_q[g];
					y_d  = sx(v_q[rows ? c : r]);
				end else if (j == 2'd3) begin
					x_d = -sx(a_q[cmd.k]);
					y_d = ONE;
				end
			end
			default: ;
		endcase

		ctl_d.valid = cmd.valid;
		ctl_d.first = cmd.first;
		ctl_d.last  = cmd.last;
		ctl_d.k     = cmd.k;
		if (cmd.pass) ctl_d.dest = mm3_pkg::DEST_RES;
		else if (cmd.mode == mm3_pkg::MODE_ABC || cmd.mode == mm3_pkg::MODE_ATBC)
			ctl_d.dest = mm3_pkg::DEST_E;
		else if (cmd.mode == mm3_pkg::MODE_COLNORM || cmd.mode == mm3_pkg::MODE_ROWNORM)
			ctl_d.dest = mm3_pkg::DEST_S;
		else ctl_d.dest = mm3_pkg::DEST_RES;
	end

	// control through the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1       <= ctl_d;
			ctl_s2       <= ctl_s1;
			ctl_s3.valid <= ctl_s2.valid && ctl_s2.last;
			ctl_s3.first <= ctl_s2.first;
			ctl_s3.last  <= ctl_s2.last;
			ctl_s3.dest  <= ctl_s2.dest;
			ctl_s3.k     <= ctl_s2.k;
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= x_d;
		y_s1    <= y_d;
		f_s1    <= xf_d;
		prod_s2 <= x_s1 * y_s1;
		f_s2    <= f_s1;
	end

	always_comb begin
		acc_n = (ctl_s2.first ? '0 : acc_q) + AW'(prod_s2);
		f_n   = (ctl_s2.first ? 1'b0 : f_acc_q) | f_s2;
	end

	always_ff @(posedge clk) begin
		if (ctl_s2.valid) begin
			acc_q   <= acc_n;
			f_acc_q <= f_n;
			sum_s3  <= acc_n;
			f_s3    <= f_n;
		end
	end

	// round half up, then saturate
	always_comb begin
		rnd    = (sum_s3 + HALF) >>> FRACTION_BITS;
		sat_hi = rnd > SAT_MAX;
		sat_lo = rnd < SAT_MIN;
		if (sat_hi) out_v = SAT_MAX[mm3_pkg::ELEM_W-1:0];
		else if (sat_lo) out_v = SAT_MIN[mm3_pkg::ELEM_W-1:0];
		else out_v = rnd[mm3_pkg::ELEM_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (ctl_s3.valid) begin
			case (ctl_s3.dest)
				mm3_pkg::DEST_E: begin
					e_q[ctl_s3.k]  <= out_v;
					ef_q[ctl_s3.k] <= f_s3 | sat_hi | sat_lo;
				end
				mm3_pkg::DEST_S: begin
					s_q[ctl_s3.k[1:0]]  <= out_v;
					sf_q[ctl_s3.k[1:0]] <= f_s3 | sat_hi | sat_lo;
				end
				default: begin
					r_q[ctl_s3.k]  <= out_v;
					rf_q[ctl_s3.k] <= f_s3 | sat_hi | sat_lo;
				end
			endcase
		end
	end

	assign res_value = r_q[emit_idx];
	assign res_ovf   = rf_q[emit_idx];

endmodule
`default_nettype wire
